/* hdl/wsm_pkg.sv */
// Shared types and constants for the wildcard star pattern matcher.
package wsm_pkg;

    // Default pattern capacity in elements.
    localparam int PATTERN_MAX_DEF = 16;

    // Command queue depth between front and back; must be a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Pattern byte that matches any text byte.
    localparam logic [7:0] ANY_BYTE = 8'h2E;

    // Stream widths.
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_TEXT   = 2'd1,
        OP_END    = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // Classified request as it travels through the queue.
    typedef struct packed {
        t_op        op;
        logic [7:0] char_byte;  // pattern byte for appends, text byte otherwise
        logic       star;       // element repeats zero or more times
        logic       any;        // element byte is the wildcard
    } t_cmd;

endpackage

/* hdl/wildcard_star_pattern_matcher.sv */
// Top level of the wildcard star pattern matcher: front end, command queue, back end.
//
// Whole-string matcher for patterns made of literal bytes, the wildcard 0x2E
// and elements repeated zero or more times. Requests arrive on the slave
// stream with the operation in tuser: append a pattern element, one text
// byte, end of text, or clear the pattern. Only end of text produces a
// result request on the master stream (match bit and sticky overflow bit);
// the set of active positions is then re-armed and the pattern is kept.
// Appends past PATTERN_MAX elements are dropped and set the overflow flag
// until the next clear. The block sustains one request per clock unless an
// end of text request waits in the back end: the active set over
// PATTERN_MAX+1 positions is updated bit-parallel, with the skips over
// starred elements resolved by a log2-depth prefix network. An accepted
// request is written into a four-entry queue and read from it by the back
// end, which registers an end result in the output register that drives
// the master side. Only an end of text request can wait in the back end, and
// only while the previous result is still held in the output register; the
// queue keeps accepting meanwhile until it fills.
module wildcard_star_pattern_matcher #(
    parameter int PATTERN_MAX = wsm_pkg::PATTERN_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [7:0] pattern_char, [8] pattern_star, [16:9] text_char, [23:17] zero
    input  logic [wsm_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // [1:0] operation
    input  logic [wsm_pkg::S_TUSER_W-1:0]   i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [0] matched, [1] pattern_overflow, [7:2] zero
    output logic [wsm_pkg::M_TDATA_W-1:0]   o_m_axis_tdata
);

    logic           fe_valid, fe_ready;
    wsm_pkg::t_cmd  fe_cmd;
    logic           be_valid, be_ready;
    wsm_pkg::t_cmd  be_cmd;
    logic           res_matched, res_ovf;

    wsm_front u_front (
        .i_s_valid   (i_s_axis_tvalid),
        .o_s_ready   (o_s_axis_tready),
        .i_s_data    (i_s_axis_tdata),
        .i_s_user    (i_s_axis_tuser),
        .o_cmd_valid (fe_valid),
        .i_cmd_ready (fe_ready),
        .o_cmd       (fe_cmd)
    );

    wsm_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fe_valid),
        .o_wr_ready (fe_ready),
        .i_wr_cmd   (fe_cmd),
        .o_rd_valid (be_valid),
        .i_rd_ready (be_ready),
        .o_rd_cmd   (be_cmd)
    );

    wsm_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (be_valid),
        .o_cmd_ready (be_ready),
        .i_cmd       (be_cmd),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_matched   (res_matched),
        .o_overflow  (res_ovf)
    );

    assign o_m_axis_tdata = {{(wsm_pkg::M_TDATA_W-2){1'b0}}, res_ovf, res_matched};

    // A full queue always has something for the back end.
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fe_ready |-> be_valid)
        else $error("queue full but reports empty");

    // The back end holds a request only for an end of text behind an untaken result.
    a_stall_only_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (be_valid && !be_ready) |-> (be_cmd.op == wsm_pkg::OP_END && o_m_axis_tvalid))
        else $error("back end stalled on a request other than end of text");

    // A new result only follows an end of text taken by the back end.
    a_result_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(be_valid && be_ready && be_cmd.op == wsm_pkg::OP_END))
        else $error("result appeared without an end of text request");

endmodule

/* hdl/wsm_front.sv */
// Front end: unpacks an input request and classifies it into a queue command.
module wsm_front (
    input  logic                            i_s_valid,
    output logic                            o_s_ready,
    input  logic [wsm_pkg::S_TDATA_W-1:0]   i_s_data,
    input  logic [wsm_pkg::S_TUSER_W-1:0]   i_s_user,
    output logic                            o_cmd_valid,
    input  logic                            i_cmd_ready,
    output wsm_pkg::t_cmd                   o_cmd
);

    logic [7:0] pattern_char;
    logic       pattern_star;
    logic [7:0] text_char;
    wsm_pkg::t_op op;

    assign pattern_char = i_s_data[7:0];
    assign pattern_star = i_s_data[8];
    assign text_char    = i_s_data[16:9];
    assign op           = wsm_pkg::t_op'(i_s_user);

    always_comb begin
        o_cmd.op        = op;
        o_cmd.char_byte = text_char;
        o_cmd.star      = 1'b0;
        o_cmd.any       = 1'b0;
        unique case (op)
            wsm_pkg::OP_APPEND: begin
                o_cmd.char_byte = pattern_char;
                o_cmd.star      = pattern_star;
                o_cmd.any       = (pattern_char == wsm_pkg::ANY_BYTE);
            end
            wsm_pkg::OP_TEXT,
            wsm_pkg::OP_END,
            wsm_pkg::OP_CLEAR: begin
                o_cmd.char_byte = text_char;
            end
            default: begin
                o_cmd.char_byte = text_char;
            end
        endcase
    end

    assign o_cmd_valid = i_s_valid;
    assign o_s_ready   = i_cmd_ready;

endmodule

/* hdl/wsm_queue.sv */
// Short command queue that decouples the front end from the back end.
module wsm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_valid,
    output logic            o_wr_ready,
    input  wsm_pkg::t_cmd   i_wr_cmd,
    output logic            o_rd_valid,
    input  logic            i_rd_ready,
    output wsm_pkg::t_cmd   o_rd_cmd
);

    wsm_pkg::t_cmd               r_slot [wsm_pkg::QUEUE_DEPTH];
    logic [wsm_pkg::QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [wsm_pkg::QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [wsm_pkg::QCNT_W-1:0]  r_count,  n_count;
    logic                        push, pop;

    assign o_wr_ready = (r_count != wsm_pkg::QCNT_W'(wsm_pkg::QUEUE_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_cmd   = r_slot[r_rd_ptr];

    assign push = i_wr_valid && o_wr_ready;
    assign pop  = o_rd_valid && i_rd_ready;

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_wr_cmd;
        end
    end

endmodule

/* hdl/wsm_back.sv */
// Back end: pattern store, active-position set update and result register.
module wsm_back #(
    parameter int PATTERN_MAX = wsm_pkg::PATTERN_MAX_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    output logic            o_cmd_ready,
    input  wsm_pkg::t_cmd   i_cmd,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output logic            o_matched,
    output logic            o_overflow
);

    localparam int NPOS  = PATTERN_MAX + 1;
    localparam int LEN_W = $clog2(NPOS);
    localparam int IDX_W = $clog2(PATTERN_MAX);
    localparam int LVLS  = $clog2(NPOS);

    logic [7:0]             r_byte [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] r_star;
    logic [PATTERN_MAX-1:0] r_any;
    logic [LEN_W-1:0]       r_len, n_len;
    logic [NPOS-1:0]        r_act, n_act;
    logic                   r_ovf, n_ovf;
    logic                   r_out_valid, n_out_valid;
    logic                   r_out_matched, n_out_matched;
    logic                   r_out_ovf, n_out_ovf;

    logic                   cmd_fire;
    logic                   wr_en;
    logic [PATTERN_MAX-1:0] en;
    logic [LVLS:0][NPOS-1:0] pg;    // closure prefix: reached
    logic [LVLS:0][NPOS-1:0] pp;    // closure prefix: skip chain unbroken
    logic [NPOS-1:0]        closed;
    logic [NPOS-1:0]        stepped;

    // An end request waits only while an untaken result sits in the output register.
    assign o_cmd_ready = (i_cmd.op != wsm_pkg::OP_END) || !r_out_valid || i_res_ready;
    assign cmd_fire    = i_cmd_valid && o_cmd_ready;

    generate
        for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_en
            assign en[j] = (LEN_W'(j) < r_len);
        end
    endgenerate

    // Skip closure over starred elements as a log-depth prefix.
    assign pg[0]    = r_act;
    assign pp[0][0] = 1'b0;
    generate
        for (genvar k = 1; k < NPOS; k++) begin : g_p0
            assign pp[0][k] = r_star[k-1] && en[k-1];
        end
        for (genvar l = 0; l < LVLS; l++) begin : g_lvl
            for (genvar k = 0; k < NPOS; k++) begin : g_pos
                if (k >= (1 << l)) begin : g_mix
                    assign pg[l+1][k] = pg[l][k] | (pp[l][k] & pg[l][k-(1<<l)]);
                    assign pp[l+1][k] = pp[l][k] & pp[l][k-(1<<l)];
                end else begin : g_keep
                    assign pg[l+1][k] = pg[l][k];
                    assign pp[l+1][k] = pp[l][k];
                end
            end
        end
    endgenerate
    assign closed = pg[LVLS];

    always_comb begin
        logic hit;
        stepped = '0;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            hit = en[j] && closed[j] && (r_any[j] || (r_byte[j] == i_cmd.char_byte));
            if (hit && r_star[j]) begin
                stepped[j] = 1'b1;
            end
            if (hit && !r_star[j]) begin
                stepped[j+1] = 1'b1;
            end
        end
    end

    always_comb begin
        n_len         = r_len;
        n_act         = r_act;
        n_ovf         = r_ovf;
        n_out_valid   = r_out_valid && !i_res_ready;
        n_out_matched = r_out_matched;
        n_out_ovf     = r_out_ovf;
        wr_en         = 1'b0;
        if (cmd_fire) begin
            unique case (i_cmd.op)
                wsm_pkg::OP_APPEND: begin
                    if (r_len < LEN_W'(PATTERN_MAX)) begin
                        wr_en = 1'b1;
                        n_len = r_len + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                wsm_pkg::OP_TEXT: begin
                    n_act = stepped;
                end
                wsm_pkg::OP_END: begin
                    n_out_valid   = 1'b1;
                    n_out_matched = closed[r_len];
                    n_out_ovf     = r_ovf;
                    n_act         = NPOS'(1);
                end
                wsm_pkg::OP_CLEAR: begin
                    n_len = '0;
                    n_ovf = 1'b0;
                    n_act = NPOS'(1);
                end
                default: begin
                    n_act = r_act;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_act       <= NPOS'(1);
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_act       <= n_act;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_matched <= n_out_matched;
        r_out_ovf     <= n_out_ovf;
        if (wr_en) begin
            r_byte[r_len[IDX_W-1:0]] <= i_cmd.char_byte;
            r_star[r_len[IDX_W-1:0]] <= i_cmd.star;
            r_any[r_len[IDX_W-1:0]]  <= i_cmd.any;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_matched   = r_out_matched;
    assign o_overflow  = r_out_ovf;

endmodule
